### hdl/sss_pkg.sv
// Package with payload types, register indexes and widths for the swept sphere test.
package sss_pkg;

  typedef struct packed {
    logic signed [31:0] other_pos_x;
    logic signed [31:0] other_pos_y;
    logic signed [31:0] other_pos_z;
    logic signed [31:0] other_vel_x;
    logic signed [31:0] other_vel_y;
    logic signed [31:0] other_vel_z;
    logic [30:0]        other_radius;
    logic               last_in_batch;
  } sss_in_t;

  typedef struct packed {
    logic        hit;
    logic [15:0] item_index;
    logic [15:0] hit_slot;
    logic [31:0] hit_time;
    logic        batch_end;
  } sss_out_t;

  localparam logic [2:0] REG_POS_X  = 3'd0;
  localparam logic [2:0] REG_POS_Y  = 3'd1;
  localparam logic [2:0] REG_POS_Z  = 3'd2;
  localparam logic [2:0] REG_VEL_X  = 3'd3;
  localparam logic [2:0] REG_VEL_Y  = 3'd4;
  localparam logic [2:0] REG_VEL_Z  = 3'd5;
  localparam logic [2:0] REG_RADIUS = 3'd6;

  // Widths of the exact intermediate quantities.
  localparam int QW = 68;   // A, B magnitude, C (sums of three 66-bit squares)
  localparam int DW = 136;  // B*B and A*C
  localparam int SW = 68;   // square root of D

endpackage

### hdl/sss_mul.sv
// Shared sequential multiplier: 32x32 partial products accumulated one per cycle.
module sss_mul (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [sss_pkg::QW-1:0] a,
  input  logic [sss_pkg::QW-1:0] b,
  output logic                 done,
  output logic [sss_pkg::DW-1:0] p
);
  import sss_pkg::*;

  // Operands split into three 32-bit limbs (top limb carries 4 bits).
  logic [95:0] ar, br;
  logic [1:0]  i, j;
  logic        busy;
  logic [63:0] pp;
  logic [DW+31:0] acc;

  assign pp = ar[32*i +: 32] * br[32*j +: 32];
  assign p  = acc[DW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        ar   <= {{(96-QW){1'b0}}, a};
        br   <= {{(96-QW){1'b0}}, b};
        acc  <= '0;
        i    <= 2'd0;
        j    <= 2'd0;
        busy <= 1'b1;
      end else if (busy) begin
        // One partial product per cycle, shifted into place.
        acc <= acc + ({{(DW-32){1'b0}}, pp} << (32 * ({1'b0, i} + {1'b0, j})));
        if (j == 2'd2) begin
          j <= 2'd0;
          if (i == 2'd2) begin
            busy <= 1'b0;
            done <= 1'b1;
          end else begin
            i <= i + 2'd1;
          end
        end else begin
          j <= j + 2'd1;
        end
      end
    end
  end
endmodule

### hdl/sss_seq.sv
// Sequencer: dot products, discriminant, bitwise square root and time division.
module sss_seq (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic signed [32:0]  dv [3],
  input  logic signed [32:0]  dp [3],
  input  logic [31:0]         rsum,
  input  logic [4:0]          frac_bits,
  output logic                done,
  output logic                hit,
  output logic [31:0]         hit_time
);
  import sss_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_DOT, S_DOTW, S_BB, S_BBW, S_AC, S_ACW, S_SQ, S_SQW, S_DIV, S_DIVW, S_DONE
  } state_t;

  state_t state;
  logic [1:0]  k;
  logic [1:0]  op;          // 0: dv*dv, 1: dp*dp, 2: dv*dp, 3: rsum^2
  logic [6:0]  bitn;
  logic [QW-1:0] qa, pos, neg, ww, r2, bn, cc;
  logic [DW-1:0] b2, dd;
  logic [SW-1:0] s, num;
  logic [31:0] q;
  logic        mstart, mdone;
  logic [QW-1:0] ma, mb;
  logic [DW-1:0] mp;
  logic          sgn;

  sss_mul u_mul (
    .clk(clk), .rst(rst), .start(mstart), .a(ma), .b(mb), .done(mdone), .p(mp)
  );

  function automatic logic [QW-1:0] mag(input logic signed [32:0] v);
    logic [32:0] m;
    m = v[32] ? 33'(-v) : 33'(v);
    return {{(QW-33){1'b0}}, m};
  endfunction

  // Candidate for square root and quotient bits.
  logic [SW-1:0] sc;
  logic [31:0]   qc;
  assign sc = s | (SW'(1) << bitn);
  assign qc = q | (32'd1 << bitn[4:0]);

  always_comb begin
    ma = '0;
    mb = '0;
    priority case (state)
      S_DOT: begin
        unique case (op)
          2'd0: begin ma = mag(dv[k]); mb = mag(dv[k]); end
          2'd1: begin ma = mag(dp[k]); mb = mag(dp[k]); end
          2'd2: begin ma = mag(dv[k]); mb = mag(dp[k]); end
          default: begin ma = QW'(rsum); mb = QW'(rsum); end
        endcase
      end
      // The magnitude of B is taken straight from the sums, since bn is loaded here.
      S_BB:  begin ma = neg - pos; mb = neg - pos; end
      S_AC:  begin ma = qa; mb = cc; end
      S_SQ:  begin ma = sc; mb = sc; end
      S_DIVW: begin ma = QW'(qc); mb = qa; end
      default: ;
    endcase
  end

  assign sgn = dv[k][32] ^ dp[k][32];

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      done   <= 1'b0;
      mstart <= 1'b0;
    end else begin
      done   <= 1'b0;
      mstart <= 1'b0;
      unique case (state)
        S_IDLE: if (start) begin
          qa <= '0; pos <= '0; neg <= '0; ww <= '0;
          k <= 2'd0; op <= 2'd0;
          mstart <= 1'b1;
          state <= S_DOT;
        end
        S_DOT: state <= S_DOTW;
        S_DOTW: if (mdone) begin
          unique case (op)
            2'd0: qa <= qa + mp[QW-1:0];
            2'd1: ww <= ww + mp[QW-1:0];
            2'd2: if (sgn) neg <= neg + mp[QW-1:0]; else pos <= pos + mp[QW-1:0];
            default: r2 <= mp[QW-1:0];
          endcase
          if (op == 2'd3) begin
            state <= S_BB;
            mstart <= 1'b1;
          end else begin
            if (op == 2'd2) begin
              op <= (k == 2'd2) ? 2'd3 : 2'd0;
              k  <= (k == 2'd2) ? 2'd0 : k + 2'd1;
            end else begin
              op <= op + 2'd1;
            end
            mstart <= 1'b1;
            state  <= S_DOT;
          end
        end
        S_BB: begin
          // Early exit on the sign tests.
          if (qa == '0 || pos > neg || ww < r2) begin
            hit <= 1'b0; hit_time <= '0; state <= S_DONE;
          end else begin
            bn <= neg - pos;
            cc <= ww - r2;
            state <= S_BBW;
          end
        end
        S_BBW: if (mdone) begin
          b2 <= mp; mstart <= 1'b1; state <= S_AC;
        end
        S_AC: state <= S_ACW;
        S_ACW: if (mdone) begin
          if (b2 < mp) begin
            hit <= 1'b0; hit_time <= '0; state <= S_DONE;
          end else begin
            dd <= b2 - mp; s <= '0; bitn <= 7'd66;
            mstart <= 1'b1; state <= S_SQ;
          end
        end
        S_SQ: state <= S_SQW;
        S_SQW: if (mdone) begin
          if (mp <= dd) s <= sc;
          if (bitn == 7'd0) begin
            state <= S_DIV;
          end else begin
            bitn <= bitn - 7'd1;
            mstart <= 1'b1;
            state <= S_SQ;
          end
        end
        S_DIV: begin
          // Saturation check, then start the bitwise quotient search.
          num <= bn - s;
          if ((DW'(bn - s) << frac_bits) >= (DW'(qa) << 32)) begin
            hit <= 1'b1; hit_time <= 32'hFFFF_FFFF; state <= S_DONE;
          end else begin
            q <= '0; bitn <= 7'd31; mstart <= 1'b1; state <= S_DIVW;
          end
        end
        S_DIVW: if (mdone) begin
          if (mp <= (DW'(num) << frac_bits)) q <= qc;
          if (bitn == 7'd0) begin
            hit <= 1'b1;
            hit_time <= (mp <= (DW'(num) << frac_bits)) ? qc : q;
            state <= S_DONE;
          end else begin
            bitn <= bitn - 7'd1;
            mstart <= 1'b1;
          end
        end
        S_DONE: begin done <= 1'b1; state <= S_IDLE; end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

### hdl/sphere_sphere_sweep_test.sv
// Swept sphere-sphere contact test: one item at a time through a shared multiplier.
// A new item is taken only after the previous result has been accepted at the output;
// each multiply runs on the one 32x32 multiplier (nine partial products plus handoff),
// and the 67-step root and 32-step quotient dominate the time taken for a hit.
// Reset clears the configuration registers, counters and the output valid; nothing is pending.
module sphere_sphere_sweep_test #(
  parameter int MAX_ITEMS = 65536,
  parameter int FRAC_BITS = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  sss_pkg::sss_in_t in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output sss_pkg::sss_out_t out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [2:0]       cfg_index,
  input  logic [31:0]      cfg_data
);
  import sss_pkg::*;

  logic signed [31:0] mpx, mpy, mpz, mvx, mvy, mvz;
  logic [30:0] mrad;
  logic [15:0] item_counter, hit_counter;
  logic busy, last, sdone, shit, sstart;
  logic [31:0] stime;
  logic signed [32:0] dv [3];
  logic signed [32:0] dp [3];
  logic [31:0] rsum;
  sss_in_t item;

  assign cfg_ready = 1'b1;
  assign in_ready  = !busy && !out_valid;
  assign sstart    = in_valid && in_ready;

  // Differences from the captured item.
  assign dv[0] = 33'(mvx) - 33'(item.other_vel_x);
  assign dv[1] = 33'(mvy) - 33'(item.other_vel_y);
  assign dv[2] = 33'(mvz) - 33'(item.other_vel_z);
  assign dp[0] = 33'(mpx) - 33'(item.other_pos_x);
  assign dp[1] = 33'(mpy) - 33'(item.other_pos_y);
  assign dp[2] = 33'(mpz) - 33'(item.other_pos_z);
  assign rsum  = 32'(mrad) + 32'(item.other_radius);

  logic go;
  sss_seq u_seq (
    .clk(clk), .rst(rst), .start(go), .dv(dv), .dp(dp), .rsum(rsum),
    .frac_bits(5'(FRAC_BITS)), .done(sdone), .hit(shit), .hit_time(stime)
  );

  function automatic logic [15:0] next_count(input logic [15:0] v);
    logic [24:0] n;
    n = 25'(v) + 25'd1;
    if (n >= 25'(MAX_ITEMS)) n = '0;
    return n[15:0];
  endfunction

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      mpx <= '0; mpy <= '0; mpz <= '0; mvx <= '0; mvy <= '0; mvz <= '0; mrad <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_POS_X:  mpx  <= cfg_data;
        REG_POS_Y:  mpy  <= cfg_data;
        REG_POS_Z:  mpz  <= cfg_data;
        REG_VEL_X:  mvx  <= cfg_data;
        REG_VEL_Y:  mvy  <= cfg_data;
        REG_VEL_Z:  mvz  <= cfg_data;
        REG_RADIUS: mrad <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  // Item capture, result register and batch counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0; go <= 1'b0; out_valid <= 1'b0;
      item_counter <= '0; hit_counter <= '0;
    end else begin
      go <= sstart;
      if (sstart) begin
        item <= in_data; busy <= 1'b1; last <= in_data.last_in_batch;
      end
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (sdone) begin
        busy <= 1'b0;
        out_valid <= 1'b1;
        out_data.hit        <= shit;
        out_data.item_index <= item_counter;
        out_data.hit_slot   <= shit ? hit_counter : '0;
        out_data.hit_time   <= shit ? stime : '0;
        out_data.batch_end  <= last;
        if (last) begin
          item_counter <= '0; hit_counter <= '0;
        end else begin
          item_counter <= next_count(item_counter);
          if (shit) hit_counter <= next_count(hit_counter);
        end
      end
    end
  end
endmodule
